[rtl/core/dtvp_pkg.sv]
`default_nettype none

package dtvp_pkg;

  localparam int unsigned MAX_FRACTION_DIGITS = 6;

  localparam logic [3:0] MAX_LEN = 4'd15;
  localparam logic [7:0] SEPARATOR_RESET = 8'd92;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_DOT = 8'h2E;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // Configuration port.
  localparam int unsigned APB_ADDR_W = 2;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] ADDR_SEPARATOR = 2'd0;

  // Role of a character position within a sub-value.
  localparam logic [2:0] KIND_HOUR = 3'd0;
  localparam logic [2:0] KIND_MIN = 3'd1;
  localparam logic [2:0] KIND_SEC = 3'd2;
  localparam logic [2:0] KIND_COLON = 3'd3;
  localparam logic [2:0] KIND_DOT = 3'd4;
  localparam logic [2:0] KIND_FRAC = 3'd5;

  // Overall list status on the closing result.
  localparam logic [1:0] STATUS_VALID = 2'd0;
  localparam logic [1:0] STATUS_ACCEPTABLE = 2'd1;
  localparam logic [1:0] STATUS_INVALID = 2'd2;

  typedef struct packed {
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [19:0] fraction;
    logic [2:0]  fraction_digits;
    logic [1:0]  precision;
    logic        value_present;
    logic        value_ok;
    logic        colon_form;
    logic        end_of_list;
    logic [1:0]  overall_status;
  } emit_t;

  function automatic logic [2:0] kind_at(input logic colon, input logic [3:0] p);
    logic [2:0] k;
    if (p < 4'd2) begin
      k = KIND_HOUR;
    end else if (colon) begin
      if (p == 4'd2 || p == 4'd5) k = KIND_COLON;
      else if (p < 4'd5) k = KIND_MIN;
      else if (p < 4'd8) k = KIND_SEC;
      else if (p == 4'd8) k = KIND_DOT;
      else k = KIND_FRAC;
    end else begin
      if (p < 4'd4) k = KIND_MIN;
      else if (p < 4'd6) k = KIND_SEC;
      else if (p == 4'd6) k = KIND_DOT;
      else k = KIND_FRAC;
    end
    return k;
  endfunction

  // Factor that turns a fraction of the given digit count into microseconds.
  function automatic logic [16:0] frac_scale(input logic [2:0] digits);
    logic [16:0] s;
    case (digits)
      3'd1:    s = 17'd100000;
      3'd2:    s = 17'd10000;
      3'd3:    s = 17'd1000;
      3'd4:    s = 17'd100;
      3'd5:    s = 17'd10;
      3'd6:    s = 17'd1;
      default: s = 17'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

[rtl/core/dtvp_in_if.sv]
`default_nettype none

interface dtvp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       has_char;
  logic       last;

  modport source (output valid, char_code, has_char, last, input ready);
  modport sink (input valid, char_code, has_char, last, output ready);
endinterface

`default_nettype wire

[rtl/core/dtvp_out_if.sv]
`default_nettype none

interface dtvp_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  hour;
  logic [6:0]  minute;
  logic [6:0]  second;
  logic [19:0] microsecond;
  logic [1:0]  precision;
  logic        value_present;
  logic        value_ok;
  logic        colon_form;
  logic        end_of_list;
  logic [1:0]  overall_status;

  modport source (output valid, hour, minute, second, microsecond, precision,
                  value_present, value_ok, colon_form, end_of_list, overall_status,
                  input ready);
  modport sink (input valid, hour, minute, second, microsecond, precision,
                value_present, value_ok, colon_form, end_of_list, overall_status,
                output ready);
endinterface

`default_nettype wire

[rtl/core/dicom_time_value_parser.sv]
// DICOM TM value parser. Characters of a time string enter on the chars channel, one
// item per clock with no bubbles while the snapshot stage is free; the whole parse
// state (position, form and digit accumulators) is updated in the cycle an item is
// accepted, and that update is what sets the rate. A separator item, or an item with
// last set, produces one result on the results channel; results pass through a
// snapshot register and then an output register that holds the microsecond scaling
// multiply. Results can stall while new characters keep being accepted as long as the
// snapshot stage is free. The separator character is set through the APB port (default
// backslash) and may only be changed while no string is in flight.
`default_nettype none

module dicom_time_value_parser (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [dtvp_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [dtvp_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [dtvp_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                   pready,
  dtvp_in_if.sink                                chars,
  dtvp_out_if.source                             results
);

  logic [7:0]      separator_char;
  logic            out_free;
  logic            snap_valid;
  dtvp_pkg::emit_t snap;

  dtvp_cfg u_cfg (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .separator_char (separator_char)
  );

  dtvp_scan u_scan (
    .clk            (clk),
    .rst            (rst),
    .separator_char (separator_char),
    .in_valid       (chars.valid),
    .in_ready       (chars.ready),
    .char_code      (chars.char_code),
    .has_char       (chars.has_char),
    .last           (chars.last),
    .out_free       (out_free),
    .snap_valid     (snap_valid),
    .snap           (snap)
  );

  dtvp_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap       (snap),
    .out_free   (out_free),
    .results    (results)
  );

endmodule

`default_nettype wire

[rtl/core/dtvp_cfg.sv]
`default_nettype none

module dtvp_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [dtvp_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [dtvp_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [dtvp_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                   pready,
  output logic      [7:0]                        separator_char
);

  // Only one register exists, so every write lands on it.
  always_ff @(posedge clk) begin
    if (rst) begin
      separator_char <= dtvp_pkg::SEPARATOR_RESET;
    end else if (psel && penable && pwrite) begin
      separator_char <= pwdata[7:0];
    end
  end

  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    if (paddr == dtvp_pkg::ADDR_SEPARATOR) begin
      prdata = {{(dtvp_pkg::APB_DATA_W-8){1'b0}}, separator_char};
    end
  end

endmodule

`default_nettype wire

[rtl/core/dtvp_scan.sv]
`default_nettype none

module dtvp_scan (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [7:0]             separator_char,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             char_code,
  input  wire logic                   has_char,
  input  wire logic                   last,
  input  wire logic                   out_free,
  output logic                        snap_valid,
  output dtvp_pkg::emit_t             snap
);

  logic [3:0]  char_position;
  logic        colon_mode;
  logic [6:0]  hour_acc;
  logic [6:0]  minute_acc;
  logic [6:0]  second_acc;
  logic [19:0] fraction_acc;
  logic [2:0]  fraction_digits;
  logic        subvalue_bad;
  logic        any_invalid;
  logic        any_colon_form;
  logic        list_started;

  // State after the current character is absorbed.
  logic [3:0]  pos_next;
  logic        colon_next;
  logic [6:0]  hour_next;
  logic [6:0]  minute_next;
  logic [6:0]  second_next;
  logic [19:0] fraction_next;
  logic [2:0]  digits_next;
  logic        bad_next;

  logic            accept;
  logic            is_sep;
  logic            absorb_en;
  logic            is_digit;
  logic [3:0]      digit;
  logic [2:0]      kind;
  logic            emit;
  logic            len_ok;
  logic [1:0]      prec;
  logic            ok;
  logic            invalid_next;
  logic            colon_seen_next;
  dtvp_pkg::emit_t snap_next;

  assign in_ready = !snap_valid || out_free;
  assign accept = in_valid && in_ready;

  assign is_sep = has_char && (char_code == separator_char);
  assign absorb_en = has_char && !is_sep;
  assign is_digit = char_code inside {[dtvp_pkg::CHAR_ZERO:dtvp_pkg::CHAR_NINE]};
  assign digit = is_digit ? char_code[3:0] : 4'd0;

  always_comb begin
    pos_next = char_position;
    colon_next = colon_mode;
    hour_next = hour_acc;
    minute_next = minute_acc;
    second_next = second_acc;
    fraction_next = fraction_acc;
    digits_next = fraction_digits;
    bad_next = subvalue_bad;
    if (char_position == 4'd2) begin
      kind = dtvp_pkg::kind_at(char_code == dtvp_pkg::CHAR_COLON, char_position);
    end else begin
      kind = dtvp_pkg::kind_at(colon_mode, char_position);
    end
    if (absorb_en) begin
      if (char_position == dtvp_pkg::MAX_LEN) begin
        bad_next = 1'b1;
      end else begin
        pos_next = char_position + 4'd1;
        if (char_position == 4'd2) begin
          colon_next = (char_code == dtvp_pkg::CHAR_COLON);
        end
        case (kind)
          dtvp_pkg::KIND_HOUR: begin
            if (is_digit) hour_next = 7'(11'(hour_acc) * 11'd10 + 11'(digit));
            else bad_next = 1'b1;
          end
          dtvp_pkg::KIND_MIN: begin
            if (is_digit) minute_next = 7'(11'(minute_acc) * 11'd10 + 11'(digit));
            else bad_next = 1'b1;
          end
          dtvp_pkg::KIND_SEC: begin
            if (is_digit) second_next = 7'(11'(second_acc) * 11'd10 + 11'(digit));
            else bad_next = 1'b1;
          end
          dtvp_pkg::KIND_COLON: begin
            if (char_code != dtvp_pkg::CHAR_COLON) bad_next = 1'b1;
          end
          dtvp_pkg::KIND_DOT: begin
            if (char_code != dtvp_pkg::CHAR_DOT) bad_next = 1'b1;
          end
          default: begin
            if (!is_digit || fraction_digits >= 3'(dtvp_pkg::MAX_FRACTION_DIGITS)) begin
              bad_next = 1'b1;
            end else begin
              fraction_next = 20'(24'(fraction_acc) * 24'd10 + 24'(digit));
              digits_next = fraction_digits + 3'd1;
            end
          end
        endcase
      end
    end
  end

  // Length check and precision for the sub-value as it stands after this item.
  always_comb begin
    if (colon_next) begin
      len_ok = (pos_next == 4'd5) || (pos_next == 4'd8) || (pos_next >= 4'd10);
      if (pos_next >= 4'd10) prec = 2'd3;
      else if (pos_next >= 4'd8) prec = 2'd2;
      else if (pos_next >= 4'd5) prec = 2'd1;
      else prec = 2'd0;
    end else begin
      len_ok = (pos_next == 4'd2) || (pos_next == 4'd4) || (pos_next == 4'd6) ||
               (pos_next >= 4'd8);
      if (pos_next >= 4'd8) prec = 2'd3;
      else if (pos_next >= 4'd6) prec = 2'd2;
      else if (pos_next >= 4'd4) prec = 2'd1;
      else prec = 2'd0;
    end
  end

  assign ok = len_ok && !bad_next && (hour_next <= 7'd23) && (minute_next <= 7'd59) &&
              (second_next <= 7'd59);
  assign emit = is_sep || last;
  // A separator on the closing item leaves an empty sub-value behind it.
  assign invalid_next = any_invalid || !ok || (is_sep && last);
  assign colon_seen_next = any_colon_form || colon_next;

  always_comb begin
    snap_next.hour = hour_next;
    snap_next.minute = minute_next;
    snap_next.second = second_next;
    snap_next.fraction = fraction_next;
    snap_next.fraction_digits = digits_next;
    snap_next.precision = prec;
    snap_next.value_present = 1'b1;
    snap_next.value_ok = ok;
    snap_next.colon_form = colon_next;
    snap_next.end_of_list = last;
    if (!last) snap_next.overall_status = dtvp_pkg::STATUS_VALID;
    else if (invalid_next) snap_next.overall_status = dtvp_pkg::STATUS_INVALID;
    else if (colon_seen_next) snap_next.overall_status = dtvp_pkg::STATUS_ACCEPTABLE;
    else snap_next.overall_status = dtvp_pkg::STATUS_VALID;
    // An entirely empty string closes with a bare result.
    if (last && !has_char && !list_started) begin
      snap_next = '0;
      snap_next.value_ok = 1'b1;
      snap_next.end_of_list = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else begin
      snap_valid <= (snap_valid && !out_free) || (accept && emit);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      snap <= snap_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && emit && last)) begin
      char_position <= '0;
      colon_mode <= 1'b0;
      hour_acc <= '0;
      minute_acc <= '0;
      second_acc <= '0;
      fraction_acc <= '0;
      fraction_digits <= '0;
      subvalue_bad <= 1'b0;
      any_invalid <= 1'b0;
      any_colon_form <= 1'b0;
      list_started <= 1'b0;
    end else if (accept && emit) begin
      char_position <= '0;
      colon_mode <= 1'b0;
      hour_acc <= '0;
      minute_acc <= '0;
      second_acc <= '0;
      fraction_acc <= '0;
      fraction_digits <= '0;
      subvalue_bad <= 1'b0;
      any_invalid <= invalid_next;
      any_colon_form <= colon_seen_next;
      list_started <= 1'b1;
    end else if (accept) begin
      char_position <= pos_next;
      colon_mode <= colon_next;
      hour_acc <= hour_next;
      minute_acc <= minute_next;
      second_acc <= second_next;
      fraction_acc <= fraction_next;
      fraction_digits <= digits_next;
      subvalue_bad <= bad_next;
      list_started <= list_started || has_char;
    end
  end

endmodule

`default_nettype wire

[rtl/core/dtvp_scale.sv]
`default_nettype none

module dtvp_scale (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            snap_valid,
  input  wire dtvp_pkg::emit_t snap,
  output logic                 out_free,
  dtvp_out_if.source           results
);

  logic [19:0] microsecond_next;

  assign microsecond_next =
    20'(37'(snap.fraction) * 37'(dtvp_pkg::frac_scale(snap.fraction_digits)));

  assign out_free = !results.valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else begin
      results.valid <= (results.valid && !results.ready) || snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && out_free) begin
      results.hour <= snap.hour;
      results.minute <= snap.minute;
      results.second <= snap.second;
      results.microsecond <= microsecond_next;
      results.precision <= snap.precision;
      results.value_present <= snap.value_present;
      results.value_ok <= snap.value_ok;
      results.colon_form <= snap.colon_form;
      results.end_of_list <= snap.end_of_list;
      results.overall_status <= snap.overall_status;
    end
  end

endmodule

`default_nettype wire

[rtl/core/dtvp_checker.sv]
`default_nettype none

module dtvp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        valid,
  input wire logic        ready,
  input wire logic [6:0]  hour,
  input wire logic [6:0]  minute,
  input wire logic [6:0]  second,
  input wire logic [19:0] microsecond,
  input wire logic [1:0]  precision,
  input wire logic        value_present,
  input wire logic        value_ok,
  input wire logic        end_of_list,
  input wire logic [1:0]  overall_status
);

  // A stalled result stays valid and holds its hour, microsecond and status.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(hour) && $stable(microsecond) &&
      $stable(overall_status))
    else $error("result changed while stalled");

  a_status_only_at_end: assert property (@(posedge clk) disable iff (rst)
    valid && !end_of_list |-> overall_status == dtvp_pkg::STATUS_VALID)
    else $error("list status shown before the end of the list");

  a_empty_string: assert property (@(posedge clk) disable iff (rst)
    valid && !value_present |-> end_of_list && value_ok && hour == 7'd0 &&
      precision == 2'd0 && overall_status == dtvp_pkg::STATUS_VALID)
    else $error("empty string result malformed");

  a_ok_in_range: assert property (@(posedge clk) disable iff (rst)
    valid && value_ok |-> hour <= 7'd23 && minute <= 7'd59 && second <= 7'd59)
    else $error("time field out of range on a legal value");

  a_valid_list_last_ok: assert property (@(posedge clk) disable iff (rst)
    valid && end_of_list && value_present &&
      overall_status != dtvp_pkg::STATUS_INVALID |-> value_ok)
    else $error("list not marked invalid though its last value is illegal");

endmodule

bind dicom_time_value_parser dtvp_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .valid          (results.valid),
  .ready          (results.ready),
  .hour           (results.hour),
  .minute         (results.minute),
  .second         (results.second),
  .microsecond    (results.microsecond),
  .precision      (results.precision),
  .value_present  (results.value_present),
  .value_ok       (results.value_ok),
  .end_of_list    (results.end_of_list),
  .overall_status (results.overall_status)
);

`default_nettype wire

[dv/dicom_time_value_parser_tb.sv]
`timescale 1ns / 1ps

module dicom_time_value_parser_tb;

  typedef struct packed {
    logic [7:0] code;
    logic       has_char;
    logic       last;
  } char_item_t;

  typedef struct packed {
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [19:0] microsecond;
    logic [1:0]  precision;
    logic        value_present;
    logic        value_ok;
    logic        colon_form;
    logic        end_of_list;
    logic [1:0]  overall_status;
  } time_result_t;

  localparam int CLOSE_ON_LAST_CHAR = 0;
  localparam int CLOSE_WITH_EMPTY_ITEM = 1;
  localparam int LEAVE_OPEN = 2;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [dtvp_pkg::APB_ADDR_W-1:0] paddr;
  logic [dtvp_pkg::APB_DATA_W-1:0] pwdata;
  logic [dtvp_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  dtvp_in_if chars_if ();
  dtvp_out_if results_if ();

  dicom_time_value_parser dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .chars   (chars_if),
    .results (results_if)
  );

  // Separator settings visited after the default one.
  logic [7:0] phase_separators [4] = '{8'hFF, 8'h00, dtvp_pkg::CHAR_COLON, 8'h2C};

  char_item_t   pending_chars [$];
  time_result_t expected_times [$];
  logic [7:0]   draft [$];

  int items_queued;
  int items_accepted;
  int chars_sent;
  int lists_sent;
  int results_checked;
  int fail_count;
  int idle_pct;
  int send_gap;
  int stall_left;
  int settings_used;

  // Parser state as the block should hold it.
  logic [7:0]  sep_char;
  logic [3:0]  cur_pos;
  logic        cur_colon;
  logic [6:0]  cur_hour;
  logic [6:0]  cur_minute;
  logic [6:0]  cur_second;
  logic [19:0] cur_frac;
  logic [2:0]  cur_frac_digits;
  logic        cur_broken;
  logic        list_broken;
  logic        list_has_colon;
  logic        list_open;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("Timed out with %0d results still awaited.", expected_times.size());
    $display("TEST FAILED");
    $finish;
  end

  task automatic add_expected(input time_result_t r);
    expected_times = {expected_times, r};
  endtask

  task automatic add_pending(input char_item_t it);
    pending_chars = {pending_chars, it};
  endtask

  task automatic add_draft(input logic [7:0] c);
    draft = {draft, c};
  endtask

  task automatic clear_subvalue();
    cur_pos = '0;
    cur_colon = 1'b0;
    cur_hour = '0;
    cur_minute = '0;
    cur_second = '0;
    cur_frac = '0;
    cur_frac_digits = '0;
    cur_broken = 1'b0;
  endtask

  task automatic clear_list();
    clear_subvalue();
    list_broken = 1'b0;
    list_has_colon = 1'b0;
    list_open = 1'b0;
  endtask

  task automatic absorb_char(input logic [7:0] c);
    logic        is_digit;
    int unsigned d;
    logic [2:0]  role;
    is_digit = (c >= dtvp_pkg::CHAR_ZERO) && (c <= dtvp_pkg::CHAR_NINE);
    d = is_digit ? int'(c - dtvp_pkg::CHAR_ZERO) : 0;
    if (cur_pos == dtvp_pkg::MAX_LEN) begin
      cur_broken = 1'b1;
    end else begin
      if (cur_pos == 4'd2) cur_colon = (c == dtvp_pkg::CHAR_COLON);
      // Colon form shifts every field after the hour by one or two places.
      case (cur_pos)
        4'd0, 4'd1: role = dtvp_pkg::KIND_HOUR;
        4'd2: role = cur_colon ? dtvp_pkg::KIND_COLON : dtvp_pkg::KIND_MIN;
        4'd3: role = dtvp_pkg::KIND_MIN;
        4'd4: role = cur_colon ? dtvp_pkg::KIND_MIN : dtvp_pkg::KIND_SEC;
        4'd5: role = cur_colon ? dtvp_pkg::KIND_COLON : dtvp_pkg::KIND_SEC;
        4'd6: role = cur_colon ? dtvp_pkg::KIND_SEC : dtvp_pkg::KIND_DOT;
        4'd7: role = cur_colon ? dtvp_pkg::KIND_SEC : dtvp_pkg::KIND_FRAC;
        4'd8: role = cur_colon ? dtvp_pkg::KIND_DOT : dtvp_pkg::KIND_FRAC;
        default: role = dtvp_pkg::KIND_FRAC;
      endcase
      cur_pos = cur_pos + 4'd1;
      case (role)
        dtvp_pkg::KIND_HOUR: begin
          if (is_digit) cur_hour = 7'(cur_hour * 10 + d);
          else cur_broken = 1'b1;
        end
        dtvp_pkg::KIND_MIN: begin
          if (is_digit) cur_minute = 7'(cur_minute * 10 + d);
          else cur_broken = 1'b1;
        end
        dtvp_pkg::KIND_SEC: begin
          if (is_digit) cur_second = 7'(cur_second * 10 + d);
          else cur_broken = 1'b1;
        end
        dtvp_pkg::KIND_COLON: begin
          if (c != dtvp_pkg::CHAR_COLON) cur_broken = 1'b1;
        end
        dtvp_pkg::KIND_DOT: begin
          if (c != dtvp_pkg::CHAR_DOT) cur_broken = 1'b1;
        end
        default: begin
          if (!is_digit || cur_frac_digits >= dtvp_pkg::MAX_FRACTION_DIGITS) begin
            cur_broken = 1'b1;
          end else begin
            cur_frac = 20'(cur_frac * 10 + d);
            cur_frac_digits = cur_frac_digits + 3'd1;
          end
        end
      endcase
    end
  endtask

  task automatic close_subvalue(input logic at_end, input logic extra_bad);
    time_result_t r;
    int           len;
    logic         len_ok;
    logic         ok;
    int unsigned  scale;
    len = int'(cur_pos);
    if (cur_colon) begin
      len_ok = (len == 5) || (len == 8) || (len >= 10);
      r.precision = (len >= 10) ? 2'd3 : (len >= 8) ? 2'd2 : (len >= 5) ? 2'd1 : 2'd0;
    end else begin
      len_ok = (len == 2) || (len == 4) || (len == 6) || (len >= 8);
      r.precision = (len >= 8) ? 2'd3 : (len >= 6) ? 2'd2 : (len >= 4) ? 2'd1 : 2'd0;
    end
    ok = len_ok && !cur_broken && (cur_hour <= 23) && (cur_minute <= 59) &&
         (cur_second <= 59);
    if (!ok || extra_bad) list_broken = 1'b1;
    if (cur_colon) list_has_colon = 1'b1;
    if (cur_frac_digits == 0) begin
      scale = 0;
    end else begin
      scale = 1;
      for (int k = int'(cur_frac_digits); k < dtvp_pkg::MAX_FRACTION_DIGITS; k++) begin
        scale = scale * 10;
      end
    end
    r.hour = cur_hour;
    r.minute = cur_minute;
    r.second = cur_second;
    r.microsecond = 20'(cur_frac * scale);
    r.value_present = 1'b1;
    r.value_ok = ok;
    r.colon_form = cur_colon;
    r.end_of_list = at_end;
    if (!at_end) r.overall_status = dtvp_pkg::STATUS_VALID;
    else if (list_broken) r.overall_status = dtvp_pkg::STATUS_INVALID;
    else if (list_has_colon) r.overall_status = dtvp_pkg::STATUS_ACCEPTABLE;
    else r.overall_status = dtvp_pkg::STATUS_VALID;
    add_expected(r);
  endtask

  task automatic predict_time_char(input char_item_t it);
    time_result_t empty_list;
    if (it.has_char && it.code == sep_char) begin
      list_open = 1'b1;
      // A separator that closes the string leaves an empty value behind it.
      close_subvalue(it.last, it.last);
      if (it.last) clear_list();
      else clear_subvalue();
    end else begin
      if (it.has_char) begin
        list_open = 1'b1;
        absorb_char(it.code);
      end
      if (it.last) begin
        if (!list_open) begin
          empty_list = '0;
          empty_list.value_ok = 1'b1;
          empty_list.end_of_list = 1'b1;
          empty_list.overall_status = dtvp_pkg::STATUS_VALID;
          add_expected(empty_list);
        end else begin
          close_subvalue(1'b1, 1'b0);
        end
        clear_list();
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
      fail_count++;
    end
  endtask

  // Character driver.
  always @(posedge clk) begin : drive_chars
    char_item_t nxt;
    char_item_t on_bus;
    if (rst) begin
      chars_if.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (chars_if.valid && chars_if.ready) begin
        on_bus.code = chars_if.char_code;
        on_bus.has_char = chars_if.has_char;
        on_bus.last = chars_if.last;
        predict_time_char(on_bus);
        items_accepted++;
      end
      if (!chars_if.valid || chars_if.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          chars_if.valid <= 1'b0;
        end else if (pending_chars.size() > 0) begin
          nxt = pending_chars.pop_front();
          chars_if.valid <= 1'b1;
          chars_if.char_code <= nxt.code;
          chars_if.has_char <= nxt.has_char;
          chars_if.last <= nxt.last;
          if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            send_gap <= $urandom_range(1, 7);
          end
        end else begin
          chars_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls.
  always @(posedge clk) begin : check_results
    time_result_t want;
    if (rst) begin
      results_if.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (results_if.valid && results_if.ready) begin
        results_checked++;
        if (expected_times.size() == 0) begin
          $display("%0t ns: result with nothing expected, hour %0d minute %0d end %0b",
                   $time, results_if.hour, results_if.minute, results_if.end_of_list);
          fail_count++;
        end else begin
          want = expected_times.pop_front();
          check_field("hour", 32'(want.hour), 32'(results_if.hour));
          check_field("minute", 32'(want.minute), 32'(results_if.minute));
          check_field("second", 32'(want.second), 32'(results_if.second));
          check_field("microsecond", 32'(want.microsecond),
                      32'(results_if.microsecond));
          check_field("precision", 32'(want.precision), 32'(results_if.precision));
          check_field("value_present", 32'(want.value_present),
                      32'(results_if.value_present));
          check_field("value_ok", 32'(want.value_ok), 32'(results_if.value_ok));
          check_field("colon_form", 32'(want.colon_form), 32'(results_if.colon_form));
          check_field("end_of_list", 32'(want.end_of_list),
                      32'(results_if.end_of_list));
          check_field("overall_status", 32'(want.overall_status),
                      32'(results_if.overall_status));
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        results_if.ready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        stall_left <= $urandom_range(0, 6);
        results_if.ready <= 1'b0;
      end else begin
        results_if.ready <= 1'b1;
      end
    end
  end

  task automatic push_item(input logic [7:0] code, input logic has_char, input logic last);
    char_item_t it;
    it.code = code;
    it.has_char = has_char;
    it.last = last;
    add_pending(it);
    items_queued++;
    if (has_char) chars_sent++;
  endtask

  task automatic push_text(input string s, input logic close_last);
    for (int i = 0; i < s.len(); i++) begin
      push_item(s[i], 1'b1, close_last && (i == s.len() - 1));
    end
  endtask

  task automatic push_number(input int v);
    add_draft(8'(dtvp_pkg::CHAR_ZERO + v / 10));
    add_draft(8'(dtvp_pkg::CHAR_ZERO + v % 10));
  endtask

  // One time value, mostly well formed, sometimes damaged or pure noise.
  task automatic build_subvalue();
    int   pick;
    int   prec;
    int   nfrac;
    int   start;
    int   pos;
    logic colon;
    start = draft.size();
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      repeat ($urandom_range(0, 18)) add_draft(8'($urandom_range(0, 255)));
    end else begin
      colon = ($urandom_range(0, 3) == 0);
      prec = $urandom_range(0, 3);
      nfrac = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 9) : $urandom_range(1, 6);
      push_number(($urandom_range(0, 9) == 0) ? $urandom_range(24, 99) : $urandom_range(0, 23));
      if (prec >= 1) begin
        if (colon) add_draft(dtvp_pkg::CHAR_COLON);
        push_number(($urandom_range(0, 9) == 0) ? $urandom_range(60, 99) : $urandom_range(0, 59));
      end
      if (prec >= 2) begin
        if (colon) add_draft(dtvp_pkg::CHAR_COLON);
        push_number(($urandom_range(0, 9) == 0) ? $urandom_range(60, 99) : $urandom_range(0, 59));
      end
      if (prec == 3) begin
        add_draft(dtvp_pkg::CHAR_DOT);
        repeat (nfrac) add_draft(8'(dtvp_pkg::CHAR_ZERO + $urandom_range(0, 9)));
      end
      if (pick < 30) begin
        case ($urandom_range(0, 3))
          0: begin
            pos = $urandom_range(start, draft.size() - 1);
            draft[pos] = 8'($urandom_range(0, 255));
          end
          1: void'(draft.pop_back());
          2: add_draft(8'($urandom_range(0, 255)));
          default: add_draft(dtvp_pkg::CHAR_DOT);
        endcase
      end
    end
  endtask

  task automatic send_draft(input int close_mode);
    for (int i = 0; i < draft.size(); i++) begin
      if ($urandom_range(0, 24) == 0) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      push_item(draft[i], 1'b1, close_mode == CLOSE_ON_LAST_CHAR && i == draft.size() - 1);
    end
    if (close_mode == CLOSE_WITH_EMPTY_ITEM ||
        (close_mode == CLOSE_ON_LAST_CHAR && draft.size() == 0)) begin
      push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endtask

  task automatic build_list();
    int n;
    int pick;
    draft.delete();
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      if (i > 0) add_draft(sep_char);
      build_subvalue();
    end
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      add_draft(sep_char);
      send_draft(CLOSE_ON_LAST_CHAR);
    end else if (pick < 4) begin
      send_draft(CLOSE_WITH_EMPTY_ITEM);
    end else begin
      send_draft(CLOSE_ON_LAST_CHAR);
    end
    lists_sent++;
  endtask

  task automatic random_strings(input int target);
    int start;
    start = chars_sent;
    while (chars_sent - start < target) build_list();
  endtask

  task automatic wait_for_results();
    while (items_accepted != items_queued) @(posedge clk);
    while (expected_times.size() != 0) @(posedge clk);
  endtask

  task automatic write_separator(input logic [7:0] code);
    logic [dtvp_pkg::APB_DATA_W-1:0] wdata;
    wdata = '0;
    wdata[7:0] = code;
    wait_for_results();
    // Every expected result has been taken by now; idle before the write.
    repeat (6) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= dtvp_pkg::ADDR_SEPARATOR;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sep_char = code;
    settings_used++;
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    chars_if.valid = 1'b0;
    chars_if.char_code = '0;
    chars_if.has_char = 1'b0;
    chars_if.last = 1'b0;
    results_if.ready = 1'b0;
    items_queued = 0;
    items_accepted = 0;
    chars_sent = 0;
    lists_sent = 0;
    results_checked = 0;
    fail_count = 0;
    settings_used = 1;
    idle_pct = 15;
    sep_char = dtvp_pkg::SEPARATOR_RESET;
    clear_list();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Empty string, largest legal value, colon form closed by a separator,
    // a bad digit, an empty value before a separator, and empty values in a list.
    push_item(8'h00, 1'b0, 1'b1);
    push_text("235959.999999", 1'b1);
    push_text("00:00", 1'b0);
    push_item(8'hFF, 1'b0, 1'b0);
    push_item(sep_char, 1'b1, 1'b1);
    push_text("9x", 1'b1);
    push_item(sep_char, 1'b1, 1'b1);
    push_text("07", 1'b0);
    push_item(sep_char, 1'b1, 1'b0);
    push_item(sep_char, 1'b1, 1'b0);
    push_item(8'hA5, 1'b0, 1'b1);

    idle_pct = 10;
    random_strings(180);
    // Hold the sender in the middle of a string until the block has drained.
    draft.delete();
    build_subvalue();
    add_draft(sep_char);
    send_draft(LEAVE_OPEN);
    wait_for_results();
    idle_pct = 30;
    random_strings(180);

    idle_pct = 15;
    foreach (phase_separators[i]) begin
      write_separator(phase_separators[i]);
      random_strings(40);
    end

    write_separator(dtvp_pkg::SEPARATOR_RESET);
    idle_pct = 0;
    random_strings(80);

    wait_for_results();
    repeat (10) @(posedge clk);
    $display("Sent %0d characters in %0d strings under %0d separator settings.",
             chars_sent, lists_sent, settings_used);
    $display("Checked %0d results, %0d field mismatches.", results_checked, fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/dtvp_pkg.sv
rtl/core/dtvp_in_if.sv
rtl/core/dtvp_out_if.sv
rtl/core/dtvp_cfg.sv
rtl/core/dtvp_scan.sv
rtl/core/dtvp_scale.sv
rtl/core/dicom_time_value_parser.sv
rtl/core/dtvp_checker.sv
dv/dicom_time_value_parser_tb.sv
